// File: src/lwedec_pkg.sv
`default_nettype none
package lwedec_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam int Q_W = 16;
  localparam int DIM_W = 11;
  localparam int KEY_W = 10;
  localparam int SECRET_W = 8;
  localparam int CIPHER_W = 16;
  localparam int MSG_W = 15;

  // signed 8-bit secret times zero-extended 16-bit element
  localparam int PROD_W = SECRET_W + CIPHER_W + 1;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CIPHER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 1'd1;

  localparam logic [Q_W-1:0] MODULUS_RESET = 16'd3329;
  localparam logic [DIM_W-1:0] DIMENSION_RESET = 11'd256;

endpackage
`default_nettype wire

// File: src/lwedec_queue.sv
`default_nettype none
module lwedec_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  localparam int DEPTH = lwedec_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  assign full = fill == FW'(DEPTH);
  assign empty = fill == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FW'(DEPTH))
    else $error("queue fill above depth");

endmodule
`default_nettype wire

// File: src/lwedec_front.sv
`default_nettype none
module lwedec_front #(
  parameter int MAX_DIM = lwedec_pkg::MAX_DIM_DEFAULT,
  parameter int ACC_W = lwedec_pkg::PROD_W + $clog2(MAX_DIM) + 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  operation,
  input  wire logic [lwedec_pkg::KEY_W-1:0]          key_index,
  input  wire logic signed [lwedec_pkg::SECRET_W-1:0] secret_value,
  input  wire logic [lwedec_pkg::CIPHER_W-1:0]       cipher_value,
  input  wire logic [lwedec_pkg::DIM_W-1:0]          dimension,
  output logic                                       q_push,
  output logic [lwedec_pkg::CIPHER_W+ACC_W-1:0]      q_data,
  input  wire logic                                  q_full
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int PW = lwedec_pkg::PROD_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL = 2'd1;
  localparam logic [1:0] F_ACC = 2'd2;

  logic signed [lwedec_pkg::SECRET_W-1:0] store [MAX_DIM];
  logic signed [lwedec_pkg::SECRET_W-1:0] rdata;

  logic [1:0]                         state;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   n_len;
  logic signed [ACC_W-1:0]            acc;
  logic [lwedec_pkg::CIPHER_W-1:0]    cval;
  logic signed [PW-1:0]               prod;
  logic                               accept;
  logic                               is_load;
  logic                               is_final;
  logic                               key_ok;

  assign accept = in_valid && in_ready;
  assign is_load = operation == lwedec_pkg::OP_LOAD;
  assign key_ok = 32'(key_index) < MAX_DIM;
  assign is_final = count >= n_len;
  assign in_ready = (state == F_IDLE) && !q_full;
  assign q_push = accept && !is_load && is_final;
  assign q_data = {cipher_value, acc};

  always_comb begin
    if (32'(dimension) > MAX_DIM) begin
      n_len = CNT_W'(MAX_DIM);
    end else begin
      n_len = CNT_W'(dimension);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && key_ok) begin
      store[AW'(key_index)] <= secret_value;
    end
    rdata <= store[count[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      cval <= cipher_value;
    end
    if (state == F_MUL) begin
      prod <= rdata * $signed({1'b0, cval});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
      acc <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && !is_load) begin
            if (is_final) begin
              acc <= '0;
              count <= '0;
            end else begin
              state <= F_MUL;
            end
          end
        end
        F_MUL: begin
          state <= F_ACC;
        end
        F_ACC: begin
          acc <= acc + {{(ACC_W - PW){prod[PW-1]}}, prod};
          count <= count + 1'b1;
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_DIM))
    else $error("element count above store depth");

  assert property (@(posedge clk) disable iff (rst) state == F_MUL |=> state == F_ACC)
    else $error("multiply not followed by accumulate");

  assert property (@(posedge clk) disable iff (rst)
      state == F_ACC |=> count == $past(count) + 1'b1)
    else $error("element count did not advance");

endmodule
`default_nettype wire

// File: src/lwedec_back.sv
`default_nettype none
module lwedec_back #(
  parameter int ACC_W = 36
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  input  wire logic [lwedec_pkg::CIPHER_W+ACC_W-1:0] q_data,
  output logic                                       q_pop,
  input  wire logic [lwedec_pkg::Q_W-1:0]            modulus,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [lwedec_pkg::MSG_W-1:0]               message_value,
  output logic                                       message_bit
);

  localparam int QW = lwedec_pkg::Q_W;
  localparam int CW = lwedec_pkg::CIPHER_W;
  localparam int DIFF_W = ACC_W + 1;
  localparam int DC_W = $clog2(DIFF_W + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV = 2'd1;
  localparam logic [1:0] B_FIN = 2'd2;

  logic [1:0]               state;
  logic [DC_W-1:0]          steps;
  logic [DIFF_W-1:0]        mag;
  logic                     neg;
  logic [QW-1:0]            rem;
  logic [QW-1:0]            rem_next;
  logic [QW-1:0]            q_eff;
  logic signed [DIFF_W-1:0] diff;
  logic [QW:0]              trial;
  logic [QW-1:0]            mu;
  logic [QW-1:0]            bound;
  logic [QW-1:0]            upper;
  logic                     one;
  logic                     out_load;

  assign q_eff = (modulus == '0) ? QW'(1) : modulus;
  assign q_pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    diff = $signed({{(DIFF_W - CW){1'b0}}, q_data[ACC_W +: CW]})
         - $signed({q_data[ACC_W-1], q_data[ACC_W-1:0]});
    trial = {rem, mag[DIFF_W-1]};
    if (trial >= {1'b0, q_eff}) begin
      rem_next = QW'(trial - {1'b0, q_eff});
    end else begin
      rem_next = trial[QW-1:0];
    end
    mu = (neg && rem != '0) ? q_eff - rem : rem;
    bound = q_eff >> 2;
    upper = q_eff - bound;
    one = (mu > bound) && (mu < upper);
    out_load = (state == B_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg <= diff[DIFF_W-1];
      mag <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      rem <= '0;
    end else if (state == B_DIV) begin
      mag <= mag << 1;
      rem <= rem_next;
    end
    if (out_load) begin
      message_bit <= one;
      message_value <= one ? q_eff[QW-1:1] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      steps <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            steps <= DC_W'(DIFF_W);
            state <= B_DIV;
          end
        end
        B_DIV: begin
          steps <= steps - 1'b1;
          if (steps == DC_W'(1)) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          if (out_load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) state == B_DIV |-> rem < q_eff)
    else $error("partial remainder not below modulus");

  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> message_bit == (message_value != '0))
    else $error("decoded bit disagrees with value");

endmodule
`default_nettype wire

// File: src/lwe_decrypt_dot_threshold.sv
`default_nettype none
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       s_tdata, s_tuser
// m_axis    out  m_tvalid / m_tready       m_tdata
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Load items and the closing v element are taken in F_IDLE; each u element passes
// through three steps (store read, multiply, accumulate) before the next item is taken.
// The remainder unit takes no new ciphertext until the last result is loaded for output,
// working one quotient bit per cycle, behind a two-entry queue.
// Synchronous reset; the secret store is not cleared and needs no sweep.
// m_tready low stalls the remainder unit, then the queue, then s_tready.
module lwe_decrypt_dot_threshold #(
  parameter int MAX_DIM = lwedec_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [9:0] key_index, [17:10] secret_value, [33:18] cipher_value, [39:34] zero
  input  wire logic [lwedec_pkg::S_TDATA_W-1:0]    s_tdata,
  // [0] operation
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [14:0] message_value, [15] message_bit
  output logic [lwedec_pkg::M_TDATA_W-1:0]         m_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lwedec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lwedec_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ACC_W = lwedec_pkg::PROD_W + $clog2(MAX_DIM) + 1;
  localparam int QDW = lwedec_pkg::CIPHER_W + ACC_W;

  logic [lwedec_pkg::Q_W-1:0]   modulus;
  logic [lwedec_pkg::DIM_W-1:0] dimension;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic [QDW-1:0]               q_in;
  logic [QDW-1:0]               q_out;
  logic [lwedec_pkg::MSG_W-1:0] message_value;
  logic                         message_bit;

  assign cfg_ready = 1'b1;
  assign m_tdata = {message_bit, message_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= lwedec_pkg::MODULUS_RESET;
      dimension <= lwedec_pkg::DIMENSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lwedec_pkg::REG_MODULUS: modulus <= cfg_data;
        lwedec_pkg::REG_DIMENSION: dimension <= cfg_data[lwedec_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lwedec_front #(
    .MAX_DIM(MAX_DIM),
    .ACC_W(ACC_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .operation(s_tuser),
    .key_index(s_tdata[9:0]),
    .secret_value($signed(s_tdata[17:10])),
    .cipher_value(s_tdata[33:18]),
    .dimension(dimension),
    .q_push(q_push),
    .q_data(q_in),
    .q_full(q_full)
  );

  lwedec_queue #(
    .W(QDW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_in),
    .full(q_full),
    .pop(q_pop),
    .pop_data(q_out),
    .empty(q_empty)
  );

  lwedec_back #(
    .ACC_W(ACC_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_data(q_out),
    .q_pop(q_pop),
    .modulus(modulus),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .message_value(message_value),
    .message_bit(message_bit)
  );

endmodule
`default_nettype wire
